[hdl/qtff_pkg.sv]
// ----------------------------------------------------------------------------
// qtff_pkg: shared types, constants and helpers of the trajectory feedforward
// Sizes of the coefficient store, sequencer codes, write-back tag, saturation.
// ----------------------------------------------------------------------------
package qtff_pkg;

  // Coefficients per axis (polynomial degree + 1), 4 to 8.
  localparam int COEFFS_PER_AXIS = 6;
  localparam int STORE_DEPTH     = 2 * COEFFS_PER_AXIS;
  localparam int STORE_W         = $clog2(STORE_DEPTH);
  localparam int PW_DEPTH        = COEFFS_PER_AXIS - 1;
  localparam int PW_IDX_W        = $clog2(PW_DEPTH);
  localparam int CI_W            = $clog2(COEFFS_PER_AXIS);

  // Datapath widths.
  localparam int OP_W   = 33;                 // multiplier operand
  localparam int PROD_W = 2 * OP_W;           // multiplier product
  localparam int FACT_W = 8;                  // largest factor 7*6*5
  localparam int BASE_W = PROD_W - 24;        // product >> 24
  localparam int TERM_W = BASE_W + FACT_W + 1;
  localparam int ACC_W  = 56;                 // derivative accumulator
  localparam int GPR_W  = PROD_W - 16;        // product >> 16
  localparam int DRV_W  = 54;                 // drive accumulator

  localparam logic [31:0] ONE_Q24        = 32'h0100_0000;
  localparam logic [31:0] INV_RADIUS_RST = 32'h0001_0000;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    CFG_JERK_SAME   = 3'd0,
    CFG_ACCEL_SAME  = 3'd1,
    CFG_VEL_SAME    = 3'd2,
    CFG_JERK_CROSS  = 3'd3,
    CFG_ACCEL_CROSS = 3'd4,
    CFG_VEL_CROSS   = 3'd5,
    CFG_INV_RADIUS  = 3'd6
  } cfg_e;

  // Gain slots by derivative order.
  localparam logic [1:0] DER_VEL   = 2'd0;
  localparam logic [1:0] DER_ACCEL = 2'd1;
  localparam logic [1:0] DER_JERK  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_TERM,
    ST_CLIP,
    ST_MOT,
    ST_GAIN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_POW,
    OP_TERM,
    OP_MOT,
    OP_GAIN
  } op_e;

  // Tag that travels with a product into the write-back cycle.
  typedef struct packed {
    logic                valid;
    op_e                 op;
    logic                grp;   // axis for terms, drive for gains
    logic                side;  // motor for the radius product
    logic [1:0]          jj;    // derivative order
    logic [CI_W-1:0]     p;     // power of the coefficient
    logic [PW_IDX_W-1:0] k;     // power of t being written
  } wb_tag_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  // Clip a signed product-wide value to signed 32 bits.
  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end else begin
      r.sat = 1'b1;
      r.val = v[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Derivative factor p, p(p-1), p(p-1)(p-2) for orders one to three.
  function automatic logic [FACT_W-1:0] deriv_factor(input logic [CI_W-1:0] p,
                                                     input logic [1:0]      jj);
    int pv;
    int f;
    pv = int'(p);
    case (jj)
      2'd1:    f = pv;
      2'd2:    f = pv * (pv - 1);
      2'd3:    f = pv * (pv - 1) * (pv - 2);
      default: f = 0;
    endcase
    return FACT_W'(f);
  endfunction

endpackage

[hdl/quintic_trajectory_feedforward_top.sv]
// ----------------------------------------------------------------------------
// quintic_trajectory_feedforward_top: coreXY quintic feedforward evaluator
// Stores x/y quintic coefficients, evaluates derivatives at a time, maps them
// to motor derivatives and forms two cross-coupled drives, saturating.
// ----------------------------------------------------------------------------
// Sequencing: a load item is written while idle and leaves busy low; an evaluate
//   item keeps busy high until its result strobes on done_o in the cycle busy falls.
// Sharing: a new evaluate is taken only once busy is low again; one registered
//   33x33 multiplier serves all 46 products in turn (powers are serial).
// Reset: coefficients clear to zero, gains to zero, the reciprocal radius to
//   1.0; the receiver cannot stall, so done_o is a single-cycle strobe.

module quintic_trajectory_feedforward_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic                action_i,
  input  logic [3:0]          coeff_index_i,
  input  logic signed [31:0]  coeff_value_i,
  input  logic [31:0]         time_value_i,
  // result channel
  output logic                done_o,
  output logic signed [31:0]  drive_first_o,
  output logic signed [31:0]  drive_second_o,
  output logic                saturated_o,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  qtff_pkg::state_e  state_q, state_d;
  logic              fin_q, fin_d;      // last product issued, let its write-back drain
  logic [qtff_pkg::CI_W-1:0] cnt_i_q, cnt_i_d;
  logic [1:0]        cnt_j_q, cnt_j_d;
  logic              cnt_s_q, cnt_s_d;
  logic              cnt_d_q, cnt_d_d;
  logic              flag_q, flag_d;
  qtff_pkg::wb_tag_t wb_q, wb_d;

  logic signed [qtff_pkg::OP_W-1:0]   mul_a, mul_b;
  logic signed [qtff_pkg::PROD_W-1:0] prod_d, prod_q;

  logic [31:0] coef_q [qtff_pkg::STORE_DEPTH];
  logic [31:0] gain_same_q [3];
  logic [31:0] gain_cross_q [3];
  logic [31:0] inv_radius_q;

  logic [31:0]                        time_q;
  logic [31:0]                        pw_q [qtff_pkg::PW_DEPTH];
  logic signed [qtff_pkg::ACC_W-1:0]  acc_q [2][3];
  logic signed [31:0]                 d_q [2][3];
  logic signed [31:0]                 th_q [2][3];
  logic signed [qtff_pkg::DRV_W-1:0]  drv_q [2];

  logic accept, accept_load, accept_eval;

  logic [qtff_pkg::CI_W-1:0]    p_w, pw_ra;
  logic [1:0]                   jmax;
  logic [qtff_pkg::STORE_W-1:0] coef_ra;
  logic [31:0]                  pw_rd, coef_rd, gain_rd;
  logic signed [32:0]           mot_sum;
  qtff_pkg::sat_t               mot_in_sat;

  logic                                pow_clip;
  logic signed [qtff_pkg::BASE_W-1:0]  term_base;
  logic signed [qtff_pkg::FACT_W:0]    term_fac;
  logic signed [qtff_pkg::TERM_W-1:0]  term_prod;
  logic [1:0]                          acc_j;
  qtff_pkg::sat_t                      mot_out_sat;
  qtff_pkg::sat_t                      d_sat [2][3];
  qtff_pkg::sat_t                      out_sat [2];
  logic                                clip_any;

  // --------------------------------------------------------------------------
  // Command handshake
  // --------------------------------------------------------------------------
  assign busy        = (state_q != qtff_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign accept_load = accept && (action_i == qtff_pkg::ACT_LOAD);
  assign accept_eval = accept && (action_i == qtff_pkg::ACT_EVAL);

  // --------------------------------------------------------------------------
  // Operand selection
  // --------------------------------------------------------------------------
  // Power of the coefficient under evaluation: highest power comes first.
  assign p_w     = qtff_pkg::CI_W'(qtff_pkg::COEFFS_PER_AXIS - 1) - cnt_i_q;
  assign jmax    = (p_w >= qtff_pkg::CI_W'(3)) ? 2'd3 : p_w[1:0];
  assign coef_ra = qtff_pkg::STORE_W'(cnt_i_q)
                 + (cnt_d_q ? qtff_pkg::STORE_W'(qtff_pkg::COEFFS_PER_AXIS)
                            : qtff_pkg::STORE_W'(0));
  assign coef_rd = coef_q[coef_ra];

  // t^(k-1) while building powers, t^(p-j) while forming terms.
  assign pw_ra = (state_q == qtff_pkg::ST_POW) ? (cnt_i_q - qtff_pkg::CI_W'(1))
                                               : (p_w - qtff_pkg::CI_W'(cnt_j_q));
  assign pw_rd = pw_q[pw_ra[qtff_pkg::PW_IDX_W-1:0]];

  // Motor mapping: x+y for the first motor, x-y for the second.
  assign mot_sum = cnt_s_q
    ? ({d_q[0][cnt_j_q][31], d_q[0][cnt_j_q]} - {d_q[1][cnt_j_q][31], d_q[1][cnt_j_q]})
    : ({d_q[0][cnt_j_q][31], d_q[0][cnt_j_q]} + {d_q[1][cnt_j_q][31], d_q[1][cnt_j_q]});
  assign mot_in_sat = qtff_pkg::sat32({{(qtff_pkg::PROD_W-33){mot_sum[32]}}, mot_sum});

  // Same-motor gain when the drive matches the motor, cross gain otherwise.
  assign gain_rd = (cnt_d_q == cnt_s_q) ? gain_same_q[cnt_j_q] : gain_cross_q[cnt_j_q];

  // --------------------------------------------------------------------------
  // Sequencer: next state, counters and multiplier issue
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cnt_i_d = cnt_i_q;
    cnt_j_d = cnt_j_q;
    cnt_s_d = cnt_s_q;
    cnt_d_d = cnt_d_q;
    wb_d    = '0;
    mul_a   = '0;
    mul_b   = '0;

    case (state_q)
      qtff_pkg::ST_IDLE: begin
        if (accept_eval) begin
          state_d = qtff_pkg::ST_POW;
          fin_d   = 1'b0;
          cnt_i_d = qtff_pkg::CI_W'(1);
        end
      end

      // Powers of t: each depends on the previous, so issue only when the
      // write-back slot is empty.
      qtff_pkg::ST_POW: begin
        if (fin_q) begin
          state_d = qtff_pkg::ST_TERM;
          fin_d   = 1'b0;
          cnt_i_d = '0;
          cnt_j_d = 2'd1;
          cnt_d_d = 1'b0;
        end else if (!wb_q.valid) begin
          wb_d.valid = 1'b1;
          wb_d.op    = qtff_pkg::OP_POW;
          wb_d.k     = cnt_i_q[qtff_pkg::PW_IDX_W-1:0];
          mul_a      = {1'b0, pw_rd};
          mul_b      = {1'b0, time_q};
          if (cnt_i_q == qtff_pkg::CI_W'(qtff_pkg::COEFFS_PER_AXIS - 2)) begin
            fin_d = 1'b1;
          end else begin
            cnt_i_d = cnt_i_q + qtff_pkg::CI_W'(1);
          end
        end
      end

      // One coefficient times one power per cycle; walk order j, then the
      // coefficient, then the axis. The constant term has no derivatives.
      qtff_pkg::ST_TERM: begin
        if (fin_q) begin
          state_d = qtff_pkg::ST_CLIP;
          fin_d   = 1'b0;
        end else begin
          wb_d.valid = 1'b1;
          wb_d.op    = qtff_pkg::OP_TERM;
          wb_d.grp   = cnt_d_q;
          wb_d.jj    = cnt_j_q;
          wb_d.p     = p_w;
          mul_a      = {coef_rd[31], coef_rd};
          mul_b      = {1'b0, pw_rd};
          if (cnt_j_q == jmax) begin
            cnt_j_d = 2'd1;
            if (cnt_i_q == qtff_pkg::CI_W'(qtff_pkg::COEFFS_PER_AXIS - 2)) begin
              cnt_i_d = '0;
              if (cnt_d_q) begin
                fin_d = 1'b1;
              end else begin
                cnt_d_d = 1'b1;
              end
            end else begin
              cnt_i_d = cnt_i_q + qtff_pkg::CI_W'(1);
            end
          end else begin
            cnt_j_d = cnt_j_q + 2'd1;
          end
        end
      end

      // Clip all six derivative sums at once.
      qtff_pkg::ST_CLIP: begin
        state_d = qtff_pkg::ST_MOT;
        cnt_j_d = qtff_pkg::DER_VEL;
        cnt_s_d = 1'b0;
      end

      qtff_pkg::ST_MOT: begin
        if (fin_q) begin
          state_d = qtff_pkg::ST_GAIN;
          fin_d   = 1'b0;
          cnt_j_d = qtff_pkg::DER_VEL;
          cnt_s_d = 1'b0;
          cnt_d_d = 1'b0;
        end else begin
          wb_d.valid = 1'b1;
          wb_d.op    = qtff_pkg::OP_MOT;
          wb_d.side  = cnt_s_q;
          wb_d.jj    = cnt_j_q;
          mul_a      = {mot_in_sat.val[31], mot_in_sat.val};
          mul_b      = {1'b0, inv_radius_q};
          if (cnt_j_q == qtff_pkg::DER_JERK) begin
            cnt_j_d = qtff_pkg::DER_VEL;
            if (cnt_s_q) begin
              fin_d = 1'b1;
            end else begin
              cnt_s_d = 1'b1;
            end
          end else begin
            cnt_j_d = cnt_j_q + 2'd1;
          end
        end
      end

      qtff_pkg::ST_GAIN: begin
        if (fin_q) begin
          state_d = qtff_pkg::ST_OUT;
          fin_d   = 1'b0;
        end else begin
          wb_d.valid = 1'b1;
          wb_d.op    = qtff_pkg::OP_GAIN;
          wb_d.grp   = cnt_d_q;
          mul_a      = {gain_rd[31], gain_rd};
          mul_b      = {th_q[cnt_s_q][cnt_j_q][31], th_q[cnt_s_q][cnt_j_q]};
          if (cnt_j_q == qtff_pkg::DER_JERK) begin
            cnt_j_d = qtff_pkg::DER_VEL;
            if (cnt_s_q) begin
              cnt_s_d = 1'b0;
              if (cnt_d_q) begin
                fin_d = 1'b1;
              end else begin
                cnt_d_d = 1'b1;
              end
            end else begin
              cnt_s_d = 1'b1;
            end
          end else begin
            cnt_j_d = cnt_j_q + 2'd1;
          end
        end
      end

      qtff_pkg::ST_OUT: begin
        state_d = qtff_pkg::ST_IDLE;
      end

      default: begin
        state_d = qtff_pkg::ST_IDLE;
      end
    endcase
  end

  // Shared multiplier, registered.
  assign prod_d = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Write-back arithmetic
  // --------------------------------------------------------------------------
  assign pow_clip    = |prod_q[qtff_pkg::PROD_W-1:56];
  assign term_base   = prod_q[qtff_pkg::PROD_W-1:24];
  assign term_fac    = {1'b0, qtff_pkg::deriv_factor(wb_q.p, wb_q.jj)};
  assign term_prod   = term_base * term_fac;
  assign acc_j       = wb_q.jj - 2'd1;
  assign mot_out_sat = qtff_pkg::sat32({{16{prod_q[qtff_pkg::PROD_W-1]}},
                                        prod_q[qtff_pkg::PROD_W-1:16]});

  always_comb begin
    clip_any = 1'b0;
    for (int a = 0; a < 2; a++) begin
      for (int j = 0; j < 3; j++) begin
        d_sat[a][j] = qtff_pkg::sat32({{(qtff_pkg::PROD_W-qtff_pkg::ACC_W)
                                        {acc_q[a][j][qtff_pkg::ACC_W-1]}}, acc_q[a][j]});
        clip_any    = clip_any | d_sat[a][j].sat;
      end
    end
    for (int g = 0; g < 2; g++) begin
      out_sat[g] = qtff_pkg::sat32({{(qtff_pkg::PROD_W-qtff_pkg::DRV_W)
                                     {drv_q[g][qtff_pkg::DRV_W-1]}}, drv_q[g]});
    end
  end

  // Saturation flag: cleared per evaluate, set by any clip along the way.
  always_comb begin
    flag_d = flag_q;
    if (accept_eval) begin
      flag_d = 1'b0;
    end
    if (wb_q.valid && (wb_q.op == qtff_pkg::OP_POW) && pow_clip) begin
      flag_d = 1'b1;
    end
    if (wb_q.valid && (wb_q.op == qtff_pkg::OP_MOT) && mot_out_sat.sat) begin
      flag_d = 1'b1;
    end
    if ((state_q == qtff_pkg::ST_CLIP) && clip_any) begin
      flag_d = 1'b1;
    end
    if ((state_q == qtff_pkg::ST_MOT) && !fin_q && mot_in_sat.sat) begin
      flag_d = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Control, configuration and coefficient store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= qtff_pkg::ST_IDLE;
      fin_q        <= 1'b0;
      cnt_i_q      <= '0;
      cnt_j_q      <= '0;
      cnt_s_q      <= 1'b0;
      cnt_d_q      <= 1'b0;
      flag_q       <= 1'b0;
      wb_q         <= '0;
      done_o       <= 1'b0;
      coef_q       <= '{default: '0};
      gain_same_q  <= '{default: '0};
      gain_cross_q <= '{default: '0};
      inv_radius_q <= qtff_pkg::INV_RADIUS_RST;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      cnt_i_q <= cnt_i_d;
      cnt_j_q <= cnt_j_d;
      cnt_s_q <= cnt_s_d;
      cnt_d_q <= cnt_d_d;
      flag_q  <= flag_d;
      wb_q    <= wb_d;
      done_o  <= (state_q == qtff_pkg::ST_OUT);

      // Drop loads beyond the store.
      if (accept_load && ({1'b0, coeff_index_i} < 5'(qtff_pkg::STORE_DEPTH))) begin
        coef_q[coeff_index_i[qtff_pkg::STORE_W-1:0]] <= coeff_value_i;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          qtff_pkg::CFG_JERK_SAME:   gain_same_q[qtff_pkg::DER_JERK]   <= cfg_data_i;
          qtff_pkg::CFG_ACCEL_SAME:  gain_same_q[qtff_pkg::DER_ACCEL]  <= cfg_data_i;
          qtff_pkg::CFG_VEL_SAME:    gain_same_q[qtff_pkg::DER_VEL]    <= cfg_data_i;
          qtff_pkg::CFG_JERK_CROSS:  gain_cross_q[qtff_pkg::DER_JERK]  <= cfg_data_i;
          qtff_pkg::CFG_ACCEL_CROSS: gain_cross_q[qtff_pkg::DER_ACCEL] <= cfg_data_i;
          qtff_pkg::CFG_VEL_CROSS:   gain_cross_q[qtff_pkg::DER_VEL]   <= cfg_data_i;
          qtff_pkg::CFG_INV_RADIUS:  inv_radius_q                      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;

    // Start of an evaluate: latch t, seed t^0 = 1.0, clear accumulators.
    if (accept_eval) begin
      time_q   <= time_value_i;
      pw_q[0]  <= qtff_pkg::ONE_Q24;
      acc_q    <= '{default: '0};
      drv_q    <= '{default: '0};
    end

    if (wb_q.valid) begin
      case (wb_q.op)
        qtff_pkg::OP_POW: begin
          pw_q[wb_q.k] <= pow_clip ? 32'hFFFF_FFFF : prod_q[55:24];
        end
        qtff_pkg::OP_TERM: begin
          acc_q[wb_q.grp][acc_j] <= acc_q[wb_q.grp][acc_j]
            + {{(qtff_pkg::ACC_W-qtff_pkg::TERM_W){term_prod[qtff_pkg::TERM_W-1]}},
               term_prod};
        end
        qtff_pkg::OP_MOT: begin
          th_q[wb_q.side][wb_q.jj] <= mot_out_sat.val;
        end
        qtff_pkg::OP_GAIN: begin
          drv_q[wb_q.grp] <= drv_q[wb_q.grp]
            + {{(qtff_pkg::DRV_W-qtff_pkg::GPR_W){prod_q[qtff_pkg::PROD_W-1]}},
               prod_q[qtff_pkg::PROD_W-1:16]};
        end
        default: ;
      endcase
    end

    if (state_q == qtff_pkg::ST_CLIP) begin
      for (int a = 0; a < 2; a++) begin
        for (int j = 0; j < 3; j++) begin
          d_q[a][j] <= d_sat[a][j].val;
        end
      end
    end

    // Present the item; done_o marks it for one cycle.
    if (state_q == qtff_pkg::ST_OUT) begin
      drive_first_o  <= out_sat[0].val;
      drive_second_o <= out_sat[1].val;
      saturated_o    <= flag_q | out_sat[0].sat | out_sat[1].sat;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result strobe follows the output state directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == qtff_pkg::ST_OUT))
    else $error("done strobe without output state");

  // Powers are serial: no new power issued while one is in write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qtff_pkg::ST_POW && wb_q.valid) |=> !wb_q.valid)
    else $error("power issued over a pending write-back");

  // Term products come only from the term phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_q.valid && wb_q.op == qtff_pkg::OP_TERM) |-> $past(state_q == qtff_pkg::ST_TERM))
    else $error("term write-back outside term phase");

  // Nothing is in flight while idle, clipping or presenting a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_q.valid |-> (state_q != qtff_pkg::ST_IDLE && state_q != qtff_pkg::ST_OUT
                    && state_q != qtff_pkg::ST_CLIP))
    else $error("write-back outside an issuing phase");

endmodule
